@@ sv/rv64_control_transfer_resolver_core_assert.svh @@
// Assertion macros for the control-transfer resolver.
// Both macros sample on the rising edge of clk and refer to clk in the scope
// where they are used; RV64CTR_ASSERT also refers to arst_n.
`ifndef RV64_CONTROL_TRANSFER_RESOLVER_CORE_ASSERT_SVH
`define RV64_CONTROL_TRANSFER_RESOLVER_CORE_ASSERT_SVH

// A property that is checked only while reset is released.
`define RV64CTR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A property that must hold at every edge, reset included.
`define RV64CTR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/rv64ctr_pkg.sv @@
`timescale 1ns / 1ps

package rv64ctr_pkg;

	// Major opcodes, instruction bits 6..0.
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;

	// funct3 of JALR.
	localparam logic [2:0] F3_JALR = 3'b000;

	// Distance from an instruction to the next one.
	localparam logic [63:0] INSN_BYTES = 64'd4;

	// Kind of control-transfer instruction.
	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_AUIPC,
		KIND_JAL,
		KIND_JALR,
		KIND_BRANCH
	} kind_t;

	// Branch conditions, encoded as their funct3.
	typedef enum logic [2:0] {
		BR_EQ  = 3'b000,
		BR_NE  = 3'b001,
		BR_LT  = 3'b100,
		BR_GE  = 3'b101,
		BR_LTU = 3'b110,
		BR_GEU = 3'b111
	} br_cond_t;

	// Decoded instruction handed from the decoder to the pipeline.
	typedef struct packed {
		kind_t       kind;
		br_cond_t    cond;
		logic [4:0]  rd;
		logic [31:0] imm;
	} dec_t;

endpackage

@@ sv/rv64ctr_decode.sv @@
`timescale 1ns / 1ps

module rv64ctr_decode import rv64ctr_pkg::*; (
	input  logic [31:0] instruction,
	output dec_t        dec
);

	logic [6:0]  opcode;
	logic [2:0]  funct3;
	logic [31:0] imm_u;
	logic [31:0] imm_j;
	logic [31:0] imm_i;
	logic [31:0] imm_b;

	assign opcode = instruction[6:0];
	assign funct3 = instruction[14:12];

	// Immediates of the four formats as 32-bit values; J, I and B are sign-extended.
	assign imm_u = {instruction[31:12], 12'b0};
	assign imm_j = {{12{instruction[31]}}, instruction[19:12], instruction[20],
			instruction[30:21], 1'b0};
	assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
	assign imm_b = {{20{instruction[31]}}, instruction[7], instruction[30:25],
			instruction[11:8], 1'b0};

	// Classify the word and pick the matching immediate.
	always_comb begin
		dec.kind = KIND_NONE;
		dec.cond = BR_EQ;
		dec.rd   = instruction[11:7];
		dec.imm  = imm_u;
		unique case (opcode)
			OPC_AUIPC: begin
				dec.kind = KIND_AUIPC;
				dec.imm  = imm_u;
			end
			OPC_JAL: begin
				dec.kind = KIND_JAL;
				dec.imm  = imm_j;
			end
			OPC_JALR: begin
				if (funct3 == F3_JALR) begin
					dec.kind = KIND_JALR;
				end
				dec.imm = imm_i;
			end
			OPC_BRANCH: begin
				// funct3 values 2 and 3 are not branches.
				if (funct3 != 3'b010 && funct3 != 3'b011) begin
					dec.kind = KIND_BRANCH;
					dec.cond = br_cond_t'(funct3);
				end
				dec.imm = imm_b;
			end
			default: begin
				dec.kind = KIND_NONE;
			end
		endcase
	end

endmodule

@@ sv/rv64_control_transfer_resolver_core.sv @@
`timescale 1ns / 1ps

// RV64I control-transfer resolver.
// An instruction beat (instruction, pc, rs1_value, rs2_value, execute) is taken
// at each rising edge where start is high and busy is low. busy never rises:
// the unit is a three-stage pipeline that takes a new beat every cycle.
// Stage 1 decodes the word and its immediate, stage 2 does the 64-bit target
// and link additions and the branch compare, stage 3 forms the register write
// and the next PC.
// The result of a beat is on the output ports for exactly one cycle with done
// high once the beat has passed stages 1, 2 and 3; the receiver cannot stall,
// so results leave in order at the rate at which beats came in.
// recognized tells whether the word is AUIPC, JAL, JALR or a branch. With
// execute low only classification is reported; rd_write, rd_index, rd_value
// and redirected are then zero and next_pc is pc+4.
// The asynchronous reset arst_n drops every beat in flight and clears done.
module rv64_control_transfer_resolver_core import rv64ctr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] instruction,
	input  logic [63:0] pc,
	input  logic [63:0] rs1_value,
	input  logic [63:0] rs2_value,
	input  logic        execute,
	output logic        done,
	output logic        recognized,
	output logic        rd_write,
	output logic [4:0]  rd_index,
	output logic [63:0] rd_value,
	output logic        redirected,
	output logic [63:0] next_pc
);

	dec_t dec;

	logic        valid_s1;
	dec_t        dec_s1;
	logic [63:0] pc_s1;
	logic [63:0] rs1_s1;
	logic [63:0] rs2_s1;
	logic        exec_s1;

	logic        valid_s2;
	kind_t       kind_s2;
	logic [4:0]  rd_s2;
	logic        exec_s2;
	logic        take_s2;
	logic [63:0] sum_s2;
	logic [63:0] link_s2;

	logic        valid_s3;
	logic        recog_s3;
	logic        wr_s3;
	logic [4:0]  rd_s3;
	logic [63:0] val_s3;
	logic        redir_s3;
	logic [63:0] npc_s3;

	logic [63:0] base;
	logic [63:0] imm64;
	logic        take;
	logic        is_jump;
	logic        wr;
	logic        redir;
	logic [63:0] target;

	assign busy = 1'b0;

	rv64ctr_decode u_decode (
		.instruction (instruction),
		.dec         (dec)
	);

	// Stage 1 valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// Stage 1 payload: decoded word and operands.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			dec_s1  <= dec;
			pc_s1   <= pc;
			rs1_s1  <= rs1_value;
			rs2_s1  <= rs2_value;
			exec_s1 <= execute;
		end
	end

	// JALR adds to rs1, everything else to the pc.
	assign base  = (dec_s1.kind == KIND_JALR) ? rs1_s1 : pc_s1;
	assign imm64 = {{32{dec_s1.imm[31]}}, dec_s1.imm};

	// Branch condition.
	always_comb begin
		case (dec_s1.cond)
			BR_EQ:   take = (rs1_s1 == rs2_s1);
			BR_NE:   take = (rs1_s1 != rs2_s1);
			BR_LT:   take = ($signed(rs1_s1) < $signed(rs2_s1));
			BR_GE:   take = ($signed(rs1_s1) >= $signed(rs2_s1));
			BR_LTU:  take = (rs1_s1 < rs2_s1);
			BR_GEU:  take = (rs1_s1 >= rs2_s1);
			default: take = 1'b0;
		endcase
	end

	// Stage 2 valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload: sum, link address and branch outcome.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			kind_s2 <= dec_s1.kind;
			rd_s2   <= dec_s1.rd;
			exec_s2 <= exec_s1;
			take_s2 <= take;
			sum_s2  <= base + imm64;
			link_s2 <= pc_s1 + INSN_BYTES;
		end
	end

	// Register write and redirect decisions.
	assign is_jump = (kind_s2 == KIND_JAL) || (kind_s2 == KIND_JALR);
	assign wr      = exec_s2 && (rd_s2 != 5'd0) && (is_jump || kind_s2 == KIND_AUIPC);
	assign redir   = exec_s2 && (is_jump || (kind_s2 == KIND_BRANCH && take_s2));
	assign target  = (kind_s2 == KIND_JALR) ? {sum_s2[63:1], 1'b0} : sum_s2;

	// Stage 3 valid bit, which is the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	// Stage 3 payload: the result beat.
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			recog_s3 <= (kind_s2 != KIND_NONE);
			wr_s3    <= wr;
			rd_s3    <= wr ? rd_s2 : 5'd0;
			val_s3   <= wr ? ((kind_s2 == KIND_AUIPC) ? sum_s2 : link_s2) : 64'd0;
			redir_s3 <= redir;
			npc_s3   <= redir ? target : link_s2;
		end
	end

	assign done       = valid_s3;
	assign recognized = recog_s3;
	assign rd_write   = wr_s3;
	assign rd_index   = rd_s3;
	assign rd_value   = val_s3;
	assign redirected = redir_s3;
	assign next_pc    = npc_s3;

endmodule

@@ sv/rv64ctr_checker.sv @@
`timescale 1ns / 1ps

`include "rv64_control_transfer_resolver_core_assert.svh"

module rv64ctr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [63:0] pc,
	input logic        execute,
	input logic        done,
	input logic        recognized,
	input logic        rd_write,
	input logic [4:0]  rd_index,
	input logic        redirected,
	input logic [63:0] next_pc
);

	// Every accepted beat produces its result, and every result beat comes from an accepted beat.
	`RV64CTR_ASSERT(a_latency, (start && !busy) |-> ##3 done, "result beat missing")
	`RV64CTR_ASSERT(a_no_extra, done |-> $past(start && !busy, 3), "result beat without input")
	// A write never targets x0 and needs a recognized, executed word.
	`RV64CTR_ASSERT(a_write, (done && rd_write) |-> (rd_index != 5'd0 && recognized && $past(execute, 3)), "bad register write")
	// Without a redirect the next PC is the sequential one.
	`RV64CTR_ASSERT(a_seq_pc, (done && !redirected) |-> (next_pc == $past(pc, 3) + 64'd4), "wrong sequential pc")
	// Unrecognized words have no effect.
	`RV64CTR_ASSERT_ALWAYS(a_unrec, (done && !recognized) |-> (!rd_write && !redirected), "effect from unrecognized word")

endmodule

bind rv64_control_transfer_resolver_core rv64ctr_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.pc         (pc),
	.execute    (execute),
	.done       (done),
	.recognized (recognized),
	.rd_write   (rd_write),
	.rd_index   (rd_index),
	.redirected (redirected),
	.next_pc    (next_pc)
);
